[hw/rtl/tahm_pkg.sv]
// ----------------------------------------------------------------------------
// tahm_pkg: shared types and constants of the thread activity hang monitor
// Holds field widths, snapshot capacity, request and action codes and the
// structs passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
package tahm_pkg;

   // snapshot capacity and derived widths
   localparam int MAX_THREADS = 64;
   localparam int LEN_W       = $clog2(MAX_THREADS + 1);
   localparam int ADDR_W      = $clog2(2 * MAX_THREADS);
   localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_THREADS);
   localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(MAX_THREADS);

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int TID_W  = 22;
   localparam int TIME_W = 32;
   localparam int CFG_W  = 8;
   localparam int CNT_W  = 8;

   // request type codes on the request tuser
   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_END    = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_HANG_LIMIT     = 2'd0;
   localparam logic [1:0] CSR_ACTIVITY_SLACK = 2'd1;

   // reset values of the configuration registers
   localparam logic [CFG_W-1:0] HANG_LIMIT_RESET = 8'd5;
   localparam logic [CFG_W-1:0] SLACK_RESET      = 8'd5;

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0,
      KIND_END    = 2'd1,
      KIND_CLEAR  = 2'd2
   } item_kind_type;

   typedef enum logic [1:0] {
      KILL_NONE  = 2'd0,
      KILL_TERM  = 2'd1,
      KILL_FORCE = 2'd2
   } kill_type;

   // one thread record as it arrives
   typedef struct packed {
      logic [1:0]        req_type;
      logic [TID_W-1:0]  thread_id;
      logic              is_sleeping;
      logic [TIME_W-1:0] user_time;
      logic [TIME_W-1:0] system_time;
   } req_type_fields_type;

   // classified item handed from front to back
   typedef struct packed {
      item_kind_type     kind;
      logic              store;     // record fits in the snapshot
      logic              sleeping;
      logic [LEN_W-1:0]  idx;       // slot for records, length for end
      logic [TID_W-1:0]  thread_id;
      logic [TIME_W-1:0] user_time;
      logic [TIME_W-1:0] system_time;
   } queue_entry_type;

   // one stored thread entry
   typedef struct packed {
      logic [TID_W-1:0]  thread_id;
      logic [TIME_W-1:0] user_time;
      logic [TIME_W-1:0] system_time;
   } store_entry_type;

   typedef struct packed {
      logic [CFG_W-1:0] hang_limit;
      logic [CFG_W-1:0] activity_slack;
   } cfg_type;

   typedef struct packed {
      logic             looks_hung;
      logic [CNT_W-1:0] streak_count;
      kill_type         kill_action;
      logic             snapshot_overflow;
   } rsp_fields_type;

endpackage

[hw/rtl/tahm_front.sv]
// ----------------------------------------------------------------------------
// tahm_front: request classifier
// Decodes each request, assigns a snapshot slot to thread records and
// pushes the classified item into the decoupling queue.
// ----------------------------------------------------------------------------
module tahm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tahm_pkg::req_type_fields_type   req,
   output logic                            push,
   output tahm_pkg::queue_entry_type       push_entry,
   input  logic                            queue_ready
);

   logic [tahm_pkg::LEN_W-1:0] cur_len_ff;
   logic [tahm_pkg::LEN_W-1:0] cur_len_in;
   logic                       fits;
   logic                       fire;

   assign req_ready = queue_ready;
   assign fire      = req_valid && queue_ready;
   assign fits      = (cur_len_ff < tahm_pkg::MAX_LEN);

   // classify the request
   always_comb begin
      push_entry.kind        = tahm_pkg::KIND_RECORD;
      push_entry.store       = 1'b0;
      push_entry.sleeping    = req.is_sleeping;
      push_entry.idx         = cur_len_ff;
      push_entry.thread_id   = req.thread_id;
      push_entry.user_time   = req.user_time;
      push_entry.system_time = req.system_time;
      push                   = 1'b0;
      cur_len_in             = cur_len_ff;
      unique case (req.req_type)
         tahm_pkg::REQ_RECORD: begin
            push_entry.kind  = tahm_pkg::KIND_RECORD;
            push_entry.store = fits;
            push             = fire;
            if (fire && fits) begin
               cur_len_in = cur_len_ff + 1'b1;
            end
         end
         tahm_pkg::REQ_END: begin
            push_entry.kind = tahm_pkg::KIND_END;
            push            = fire;
            if (fire) begin
               cur_len_in = '0;
            end
         end
         tahm_pkg::REQ_CLEAR: begin
            push_entry.kind = tahm_pkg::KIND_CLEAR;
            push            = fire;
            if (fire) begin
               cur_len_in = '0;
            end
         end
         default: begin
            // unused request code: taken and dropped
            push = 1'b0;
         end
      endcase
   end

   // open snapshot length
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff <= '0;
      end else begin
         cur_len_ff <= cur_len_in;
      end
   end

endmodule

[hw/rtl/tahm_queue.sv]
// ----------------------------------------------------------------------------
// tahm_queue: decoupling queue
// Short first-in first-out buffer of classified items between the front
// and the back, so either side can stall on its own.
// ----------------------------------------------------------------------------
module tahm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tahm_pkg::queue_entry_type  push_entry,
   output logic                       push_ready,
   input  logic                       pop,
   output logic                       head_valid,
   output tahm_pkg::queue_entry_type  head
);

   tahm_pkg::queue_entry_type entries_ff [tahm_pkg::QUEUE_DEPTH];
   logic [tahm_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [tahm_pkg::QPTR_W-1:0] wr_ptr_in;
   logic [tahm_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [tahm_pkg::QPTR_W-1:0] rd_ptr_in;
   logic [tahm_pkg::QCNT_W-1:0] count_ff;
   logic [tahm_pkg::QCNT_W-1:0] count_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = (count_ff != tahm_pkg::QCNT_W'(tahm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hw/rtl/tahm_back.sv]
// ----------------------------------------------------------------------------
// tahm_back: snapshot evaluator
// Reads the kept snapshot from the two-bank store, compares each record,
// stores the new snapshot and decides hang and kill on end of snapshot.
// ----------------------------------------------------------------------------
module tahm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tahm_pkg::cfg_type               cfg,
   input  logic                            head_valid,
   input  tahm_pkg::queue_entry_type       head,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tahm_pkg::rsp_fields_type        rsp
);

   // snapshot store, two banks of MAX_THREADS entries
   tahm_pkg::store_entry_type snap_mem_ff [2 * tahm_pkg::MAX_THREADS];

   // read stage
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   tahm_pkg::queue_entry_type s1_ff;
   tahm_pkg::store_entry_type rd0_ff;
   tahm_pkg::store_entry_type rd1_ff;
   logic [tahm_pkg::ADDR_W-1:0] raddr0;
   logic [tahm_pkg::ADDR_W-1:0] raddr1;
   logic                        s1_load;
   logic                        rd_en;

   // evaluate stage
   logic                          eval_fire;
   logic                          eval_end;
   logic                          mem_we;
   logic [tahm_pkg::ADDR_W-1:0]   waddr;
   tahm_pkg::store_entry_type     wdata;
   tahm_pkg::store_entry_type     old;
   logic [tahm_pkg::TIME_W:0]     ut_lim;
   logic [tahm_pkg::TIME_W:0]     st_lim;
   logic                          rec_active;
   logic [tahm_pkg::CNT_W-1:0]    streak_inc;

   // snapshot state
   logic                        bank_sel_ff,   bank_sel_in;
   logic                        hist_valid_ff, hist_valid_in;
   logic [tahm_pkg::LEN_W-1:0]  hist_len_ff,   hist_len_in;
   logic                        all_sleep_ff,  all_sleep_in;
   logic                        activity_ff,   activity_in;
   logic                        overflow_ff,   overflow_in;
   logic [tahm_pkg::CNT_W-1:0]  streak_ff,     streak_in;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   tahm_pkg::rsp_fields_type rsp_ff;
   tahm_pkg::rsp_fields_type rsp_in;

   // stage handshakes
   assign eval_end  = s1_valid_ff && (s1_ff.kind == tahm_pkg::KIND_END);
   assign eval_fire = s1_valid_ff && (!eval_end || !rsp_valid_ff || rsp_ready);
   assign s1_load   = !s1_valid_ff || eval_fire;
   assign pop       = head_valid && s1_load;
   assign rd_en     = pop && head.store;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (eval_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // read both banks at the slot; the bank is picked once the item evaluates
   assign raddr0 = tahm_pkg::ADDR_W'(head.idx);
   assign raddr1 = tahm_pkg::ADDR_W'(head.idx) + tahm_pkg::BANK1_BASE;

   // write of the open snapshot into the current bank
   assign mem_we = eval_fire && (s1_ff.kind == tahm_pkg::KIND_RECORD) && s1_ff.store;
   assign waddr  = bank_sel_ff ? tahm_pkg::ADDR_W'(s1_ff.idx) + tahm_pkg::BANK1_BASE
                               : tahm_pkg::ADDR_W'(s1_ff.idx);
   assign wdata.thread_id   = s1_ff.thread_id;
   assign wdata.user_time   = s1_ff.user_time;
   assign wdata.system_time = s1_ff.system_time;

   // store with write-through on a same-cycle address match
   always_ff @(posedge clock) begin
      if (mem_we) begin
         snap_mem_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rd0_ff <= (mem_we && (waddr == raddr0)) ? wdata : snap_mem_ff[raddr0];
         rd1_ff <= (mem_we && (waddr == raddr1)) ? wdata : snap_mem_ff[raddr1];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= head;
      end
   end

   // compare a record against the kept entry in the other bank
   assign old    = bank_sel_ff ? rd0_ff : rd1_ff;
   assign ut_lim = {1'b0, old.user_time} + (tahm_pkg::TIME_W + 1)'(cfg.activity_slack);
   assign st_lim = {1'b0, old.system_time} + (tahm_pkg::TIME_W + 1)'(cfg.activity_slack);
   assign rec_active = (old.thread_id != s1_ff.thread_id) ||
                       ({1'b0, s1_ff.user_time} > ut_lim) ||
                       ({1'b0, s1_ff.system_time} > st_lim);
   assign streak_inc = (streak_ff == '1) ? streak_ff : streak_ff + 1'b1;

   // snapshot state update and end-of-snapshot decision
   always_comb begin
      bank_sel_in   = bank_sel_ff;
      hist_valid_in = hist_valid_ff;
      hist_len_in   = hist_len_ff;
      all_sleep_in  = all_sleep_ff;
      activity_in   = activity_ff;
      overflow_in   = overflow_ff;
      streak_in     = streak_ff;
      rsp_in        = '0;
      if (eval_fire) begin
         unique case (s1_ff.kind)
            tahm_pkg::KIND_RECORD: begin
               if (!s1_ff.sleeping) begin
                  all_sleep_in = 1'b0;
               end
               if (!s1_ff.store) begin
                  overflow_in = 1'b1;
               end else if (hist_valid_ff && (s1_ff.idx < hist_len_ff) && rec_active) begin
                  activity_in = 1'b1;
               end
            end
            tahm_pkg::KIND_END: begin
               priority if (overflow_ff) begin
                  rsp_in.snapshot_overflow = 1'b1;
                  hist_valid_in = 1'b0;
                  streak_in     = '0;
               end else if (!all_sleep_ff) begin
                  hist_valid_in = 1'b0;
                  streak_in     = '0;
               end else if (!hist_valid_ff || (hist_len_ff != s1_ff.idx)) begin
                  hist_valid_in = 1'b1;
                  hist_len_in   = s1_ff.idx;
                  bank_sel_in   = !bank_sel_ff;
                  streak_in     = '0;
               end else if (activity_ff) begin
                  hist_valid_in = 1'b0;
                  streak_in     = '0;
               end else begin
                  rsp_in.looks_hung = 1'b1;
                  streak_in         = streak_inc;
                  if (streak_inc > cfg.hang_limit) begin
                     rsp_in.kill_action = (streak_ff > cfg.hang_limit) ?
                                          tahm_pkg::KILL_FORCE : tahm_pkg::KILL_TERM;
                  end
                  hist_valid_in = 1'b1;
                  hist_len_in   = s1_ff.idx;
                  bank_sel_in   = !bank_sel_ff;
               end
               rsp_in.streak_count = streak_in;
               all_sleep_in = 1'b1;
               activity_in  = 1'b0;
               overflow_in  = 1'b0;
            end
            tahm_pkg::KIND_CLEAR: begin
               hist_valid_in = 1'b0;
               streak_in     = '0;
               all_sleep_in  = 1'b1;
               activity_in   = 1'b0;
               overflow_in   = 1'b0;
            end
            default: begin
               all_sleep_in = all_sleep_ff;
            end
         endcase
      end
   end

   // response slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eval_fire && eval_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_fire && eval_end) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bank_sel_ff   <= 1'b0;
         hist_valid_ff <= 1'b0;
         hist_len_ff   <= '0;
         all_sleep_ff  <= 1'b1;
         activity_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
         streak_ff     <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         bank_sel_ff   <= bank_sel_in;
         hist_valid_ff <= hist_valid_in;
         hist_len_ff   <= hist_len_in;
         all_sleep_ff  <= all_sleep_in;
         activity_ff   <= activity_in;
         overflow_ff   <= overflow_in;
         streak_ff     <= streak_in;
      end
   end

   // a kill request only comes with a hung snapshot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kill_action != tahm_pkg::KILL_NONE)) |-> rsp_ff.looks_hung)
      else $error("kill request without hung snapshot");

   // an overflowing snapshot never looks hung
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.snapshot_overflow) |-> !rsp_ff.looks_hung)
      else $error("overflowing snapshot reported hung");

   // every evaluated end of snapshot leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      (eval_fire && eval_end) |=> rsp_valid_ff)
      else $error("end of snapshot produced no response");

   // kept length never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      hist_len_ff <= tahm_pkg::MAX_LEN)
      else $error("kept snapshot length beyond capacity");

endmodule

[hw/rtl/thread_activity_hang_monitor.sv]
// ----------------------------------------------------------------------------
// thread_activity_hang_monitor: hang watchdog over thread snapshots
// Takes thread records one per request, compares each snapshot with the
// kept one and reports hang count and kill requests per closed snapshot.
//
//   channel  direction  signals                          payload
//   req      in         req_tvalid/tready/tdata/tuser    thread record, type
//   rsp      out        rsp_tvalid/tready/tdata          hang verdict per end
//   csr      in         csr_valid/ready/index/data       0 hang_limit, 1 slack
//
// One request per cycle sustained while responses are taken; a request passes
// the queue, the store read and the evaluate stage before its response is
// registered in the output slot.
// The rate is set by the single write and two-bank read of the snapshot store.
// Reset clears history, hang count and open snapshot; no clearing pass.
// A stalled response holds the evaluator; requests still fill the 4-entry queue.
// ----------------------------------------------------------------------------
module thread_activity_hang_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // thread_id[21:0], is_sleeping[22], user_time[54:23], system_time[86:55]
   input  logic [87:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // looks_hung[0], streak_count[8:1], kill_action[10:9], snapshot_overflow[11]
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   tahm_pkg::req_type_fields_type req;
   tahm_pkg::queue_entry_type     push_entry;
   tahm_pkg::queue_entry_type     head;
   tahm_pkg::rsp_fields_type      rsp;
   tahm_pkg::cfg_type             cfg;
   logic                          push;
   logic                          queue_ready;
   logic                          pop;
   logic                          head_valid;

   logic [tahm_pkg::CFG_W-1:0] hang_limit_ff, hang_limit_in;
   logic [tahm_pkg::CFG_W-1:0] slack_ff,      slack_in;

   // request unpacking
   assign req.req_type    = req_tuser;
   assign req.thread_id   = req_tdata[21:0];
   assign req.is_sleeping = req_tdata[22];
   assign req.user_time   = req_tdata[54:23];
   assign req.system_time = req_tdata[86:55];

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      hang_limit_in = hang_limit_ff;
      slack_in      = slack_ff;
      if (csr_valid) begin
         if (csr_index == tahm_pkg::CSR_HANG_LIMIT) begin
            hang_limit_in = csr_data;
         end else if (csr_index == tahm_pkg::CSR_ACTIVITY_SLACK) begin
            slack_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hang_limit_ff <= tahm_pkg::HANG_LIMIT_RESET;
         slack_ff      <= tahm_pkg::SLACK_RESET;
      end else begin
         hang_limit_ff <= hang_limit_in;
         slack_ff      <= slack_in;
      end
   end

   assign cfg.hang_limit     = hang_limit_ff;
   assign cfg.activity_slack = slack_ff;

   tahm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (queue_ready)
   );

   tahm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   tahm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // response packing
   assign rsp_tdata = {4'b0000, rsp.snapshot_overflow, rsp.kill_action,
                       rsp.streak_count, rsp.looks_hung};

endmodule
